// ----- design/page_frame_allocator_refcount_assert.svh -----
// Assertion macros for the page frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_ASSERT_SVH

`ifndef SYNTHESIS
`define PFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PFA_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFA_ASSERT(lbl, clk, rst, prop, msg)
`define PFA_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ----- design/pfa_pkg.sv -----
`default_nettype none

package pfa_pkg;

   localparam int ADDR_W      = 64;
   localparam int PFN_W       = 52;
   localparam int PAGE_SHIFT  = 12;
   localparam int CNT_W       = 17;
   localparam int CNT_MAX_INT = 131071;
   localparam int OUT_REF_W   = 16;
   localparam int ACT_W       = 3;
   localparam int STAT_W      = 3;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CNT_W-1:0] CNT_MAX       = 17'h1FFFF;
   localparam logic [CNT_W-1:0] RESERVE_RESET = 17'd5;

   localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
   localparam logic [ACT_W-1:0] ACT_FREE  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_INC   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DEC   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_QUERY = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_OOM       = 3'd1;
   localparam logic [STAT_W-1:0] ST_ADDR      = 3'd2;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd3;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_FRAMES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE     = 2'd2;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ADDR_W-1:0] addr;
      logic              in_pool;
   } req_entry_type;

   typedef struct packed {
      logic          valid;
      req_entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    page;
      logic [OUT_REF_W-1:0] ref_value;
      logic [STAT_W-1:0]    status;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/pfa_ram.sv -----
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ----- design/pfa_front.sv -----
`default_nettype none

module pfa_front #(
   parameter int NUM_FRAMES = 65536
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [pfa_pkg::ADDR_W-1:0]     req_tdata,
   input  wire logic [pfa_pkg::ACT_W-1:0]      req_tuser,
   input  wire logic [pfa_pkg::PFN_W-1:0]      pool_base,
   input  wire logic [pfa_pkg::CNT_W-1:0]      pool_size,
   input  wire logic                           clearing,
   input  wire logic                           pop,
   output pfa_pkg::queue_head_type             head,
   output logic      [$clog2(NUM_FRAMES)-1:0]  head_frame
);

   import pfa_pkg::*;

   localparam int FW = $clog2(NUM_FRAMES);

   logic [PFN_W-1:0]  pfn;
   logic [PFN_W:0]    diff;
   logic              in_pool;
   logic              push;
   req_entry_type     new_entry;

   req_entry_type     entry_ff [2];
   logic [FW-1:0]     frame_ff [2];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [1:0]        count_ff, count_in;

   // A page is in the pool when its frame number minus the base is below the pool size.
   assign pfn     = req_tdata[ADDR_W-1:PAGE_SHIFT];
   assign diff    = {1'b0, pfn} - {1'b0, pool_base};
   assign in_pool = !diff[PFN_W] && (diff[PFN_W-1:CNT_W] == '0)
                    && (diff[CNT_W-1:0] < pool_size);

   assign new_entry = '{action: req_tuser, addr: req_tdata, in_pool: in_pool};

   assign req_tready = (count_ff != 2'd2) && !clearing;
   assign push       = req_tvalid && req_tready;

   assign head.valid = (count_ff != 2'd0);
   assign head.entry = entry_ff[rptr_ff];
   assign head_frame = frame_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= new_entry;
         frame_ff[wptr_ff] <= diff[FW-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- design/pfa_back.sv -----
`default_nettype none

module pfa_back #(
   parameter int NUM_FRAMES = 65536,
   parameter int REF_WIDTH  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          restart,
   input  wire logic [pfa_pkg::CNT_W-1:0]     pool_size_new,
   input  wire logic [pfa_pkg::CNT_W-1:0]     pool_size,
   input  wire logic [pfa_pkg::CNT_W-1:0]     reserve,
   input  wire logic [pfa_pkg::PFN_W-1:0]     pool_base,
   input  wire pfa_pkg::queue_head_type       head,
   input  wire logic [$clog2(NUM_FRAMES)-1:0] head_frame,
   output logic                               pop,
   output logic                               clearing,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output pfa_pkg::rsp_type                   rsp
);

   import pfa_pkg::*;

   localparam int FW = $clog2(NUM_FRAMES);
   localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_READ  = 3'b010,
      S_WRITE = 3'b100
   } state_type;

   function automatic logic [OUT_REF_W-1:0] ref_out(input logic [REF_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[OUT_REF_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [FW-1:0]      clr_ff, clr_in;
   req_entry_type      op_ff, op_in;
   logic [FW-1:0]      frame_ff, frame_in;
   logic               alloc_ok_ff, alloc_ok_in;
   logic               use_freed_ff, use_freed_in;
   logic [ADDR_W-1:0]  page_ff, page_in;
   logic [FW-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]   depth_ff, depth_in;
   logic [CNT_W-1:0]   fresh_ff, fresh_in;
   logic [CNT_W-1:0]   fcount_ff, fcount_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [FW-1:0]        alloc_frame;
   logic [PFN_W-1:0]     page_pfn;
   logic                 out_free;
   logic                 rd_en;
   logic [FW-1:0]        ref_raddr;
   logic [REF_WIDTH-1:0] ref_rdata;
   logic                 ref_we;
   logic [FW-1:0]        ref_waddr;
   logic [REF_WIDTH-1:0] ref_wdata;
   logic [REF_WIDTH-1:0] ref_new;
   logic                 link_we;
   logic [FW-1:0]        link_rdata;
   logic                 ref_at_max;

   pfa_ram #(.WIDTH(REF_WIDTH), .DEPTH(NUM_FRAMES)) u_ref_ram (
      .clock (clock),
      .we    (ref_we),
      .waddr (ref_waddr),
      .wdata (ref_wdata),
      .re    (rd_en),
      .raddr (ref_raddr),
      .rdata (ref_rdata)
   );

   pfa_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (frame_ff),
      .wdata (head_ff),
      .re    (rd_en),
      .raddr (head_ff),
      .rdata (link_rdata)
   );

   assign clearing  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign alloc_frame = (depth_ff != '0) ? head_ff : FW'(fresh_ff);
   assign page_pfn    = pool_base + PFN_W'(alloc_frame);
   assign ref_at_max  = (ref_rdata == '1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      frame_in     = frame_ff;
      alloc_ok_in  = alloc_ok_ff;
      use_freed_in = use_freed_ff;
      page_in      = page_ff;
      head_in      = head_ff;
      depth_in     = depth_ff;
      fresh_in     = fresh_ff;
      fcount_in    = fcount_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      ref_raddr    = head_frame;
      ref_we       = 1'b0;
      ref_waddr    = frame_ff;
      ref_wdata    = ref_rdata;
      ref_new      = ref_rdata;
      link_we      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ref_we    = 1'b1;
            ref_waddr = clr_ff;
            ref_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_FRAME) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (head.valid) begin
               pop          = 1'b1;
               rd_en        = 1'b1;
               op_in        = head.entry;
               use_freed_in = (depth_ff != '0);
               alloc_ok_in  = (fcount_ff >= reserve) && (fcount_ff != '0)
                              && ((depth_ff != '0) || (fresh_ff < pool_size));
               page_in      = {page_pfn, {PAGE_SHIFT{1'b0}}};
               if (head.entry.action == ACT_ALLOC) begin
                  ref_raddr = alloc_frame;
                  frame_in  = alloc_frame;
               end else begin
                  frame_in  = head_frame;
               end
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{page: op_ff.addr, ref_value: '0, status: ST_OK};
               state_in     = S_READ;
               unique case (op_ff.action) inside
                  ACT_ALLOC: begin
                     if (alloc_ok_ff) begin
                        // On alloc the reference count saturates without a flag.
                        ref_new   = ref_at_max ? ref_rdata : ref_rdata + 1'b1;
                        ref_we    = 1'b1;
                        ref_wdata = ref_new;
                        fcount_in = fcount_ff - 1'b1;
                        if (use_freed_ff) begin
                           head_in  = link_rdata;
                           depth_in = depth_ff - 1'b1;
                        end else begin
                           fresh_in = fresh_ff + 1'b1;
                        end
                        rsp_in = '{page: page_ff, ref_value: ref_out(ref_new),
                                   status: ST_OK};
                     end else begin
                        rsp_in = '{page: '0, ref_value: '0, status: ST_OOM};
                     end
                  end
                  ACT_FREE, ACT_INC, ACT_DEC, ACT_QUERY: begin
                     if (!op_ff.in_pool) begin
                        rsp_in.status = ST_ADDR;
                     end else begin
                        rsp_in.ref_value = ref_out(ref_rdata);
                        case (op_ff.action)
                           ACT_FREE: begin
                              if (depth_ff != CNT_MAX) begin
                                 link_we  = 1'b1;
                                 head_in  = frame_ff;
                                 depth_in = depth_ff + 1'b1;
                                 if (fcount_ff != CNT_MAX) begin
                                    fcount_in = fcount_ff + 1'b1;
                                 end
                              end
                           end
                           ACT_INC: begin
                              if (ref_at_max) begin
                                 rsp_in.status = ST_OVERFLOW;
                              end else begin
                                 ref_new          = ref_rdata + 1'b1;
                                 ref_we           = 1'b1;
                                 ref_wdata        = ref_new;
                                 rsp_in.ref_value = ref_out(ref_new);
                              end
                           end
                           ACT_DEC: begin
                              if (ref_rdata == '0) begin
                                 rsp_in.status = ST_UNDERFLOW;
                              end else begin
                                 ref_new          = ref_rdata - 1'b1;
                                 ref_we           = 1'b1;
                                 ref_wdata        = ref_new;
                                 rsp_in.ref_value = ref_out(ref_new);
                              end
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_READ;
         end
      endcase

      // A write of the pool size starts the allocator over; the counts are kept.
      if (restart) begin
         fcount_in = pool_size_new;
         fresh_in  = '0;
         depth_in  = '0;
         head_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         depth_ff     <= '0;
         fresh_ff     <= '0;
         fcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         depth_ff     <= depth_in;
         fresh_ff     <= fresh_in;
         fcount_ff    <= fcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      frame_ff     <= frame_in;
      alloc_ok_ff  <= alloc_ok_in;
      use_freed_ff <= use_freed_in;
      page_ff      <= page_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- design/page_frame_allocator_refcount.sv -----
// Page frame allocator with per-frame reference counts.
//
// Requests enter on the req_ stream: tuser carries the action (alloc, free,
// increment, decrement, query) and tdata the physical page address. Every
// request gives exactly one item on the rsp_ stream with the page address,
// the frame's reference count and a status code. The csr_ port sets the pool
// base frame, the pool size and the alloc reserve; writing the pool size
// restarts the free list but keeps the reference counts.
//
// An accepted request waits in the queue; the back end then reads and writes
// the synchronous count and link memories and puts the item in the output
// register, and takes the next request only after that write. A two-entry
// queue in the front end keeps accepting while the back end works or waits.
//
// After reset the count memory is cleared one frame per cycle, and req_tready
// stays low until that pass is over. When the receiver holds rsp_tready low,
// the finished item stays in the output register, the back end waits and the
// queue fills before req_tready drops.
`default_nettype none
`include "page_frame_allocator_refcount_assert.svh"

module page_frame_allocator_refcount #(
   parameter int NUM_FRAMES = 65536,
   parameter int REF_WIDTH  = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [pfa_pkg::ADDR_W-1:0]        req_tdata,  // phys_address
   input  wire logic [pfa_pkg::ACT_W-1:0]         req_tuser,  // action
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // page_address [63:0], ref_value [79:64]
   output logic      [pfa_pkg::ADDR_W+pfa_pkg::OUT_REF_W-1:0] rsp_tdata,
   output logic      [pfa_pkg::STAT_W-1:0]        rsp_tuser,  // status
   input  wire logic                              csr_we,
   input  wire logic [pfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pfa_pkg::PFN_W-1:0]         csr_wdata
);

   import pfa_pkg::*;

   localparam int FW = $clog2(NUM_FRAMES);
   localparam int SizeCapInt = (NUM_FRAMES > CNT_MAX_INT) ? CNT_MAX_INT : NUM_FRAMES;
   localparam logic [CNT_W-1:0] SIZE_CAP = CNT_W'(SizeCapInt);

   logic [PFN_W-1:0] base_ff;
   logic [CNT_W-1:0] pool_size_ff;
   logic [CNT_W-1:0] reserve_ff;
   logic [CNT_W-1:0] pool_size_new;
   logic             restart;

   queue_head_type   head;
   logic [FW-1:0]    head_frame;
   logic             pop;
   logic             clearing;
   rsp_type          rsp;

   assign pool_size_new = (csr_wdata[CNT_W-1:0] > SIZE_CAP) ? SIZE_CAP
                                                             : csr_wdata[CNT_W-1:0];
   assign restart       = csr_we && (csr_index == CSR_POOL_FRAMES);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         pool_size_ff <= '0;
         reserve_ff   <= RESERVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POOL_BASE:   base_ff      <= csr_wdata;
            CSR_POOL_FRAMES: pool_size_ff <= pool_size_new;
            CSR_RESERVE:     reserve_ff   <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pfa_front #(.NUM_FRAMES(NUM_FRAMES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pool_base  (base_ff),
      .pool_size  (pool_size_ff),
      .clearing   (clearing),
      .pop        (pop),
      .head       (head),
      .head_frame (head_frame)
   );

   pfa_back #(.NUM_FRAMES(NUM_FRAMES), .REF_WIDTH(REF_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .pool_size_new (pool_size_new),
      .pool_size     (pool_size_ff),
      .reserve       (reserve_ff),
      .pool_base     (base_ff),
      .head          (head),
      .head_frame    (head_frame),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp           (rsp)
   );

   assign rsp_tdata = {rsp.ref_value, rsp.page};
   assign rsp_tuser = rsp.status;

   `PFA_ASSERT_NR(a_clear_after_reset, clock, ($past(reset) && !reset) |-> clearing, "no clear pass")
   `PFA_ASSERT(a_no_accept_clear, clock, reset, clearing |-> !req_tready, "accepted while clearing")
   `PFA_ASSERT(a_pop_nonempty, clock, reset, pop |-> head.valid, "queue popped while empty")
   `PFA_ASSERT(a_oom_zero, clock, reset, (rsp_tvalid && (rsp_tuser == ST_OOM)) |-> (rsp_tdata == '0), "bad refusal")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import pfa_pkg::*;

   localparam int NUM_FRAMES  = 65536;
   localparam int FRAME_W     = 16;
   localparam int REF_BITS    = 16;
   localparam bit [REF_BITS-1:0] REF_TOP = '1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_STALL  = 400;
   localparam int HOT_WINDOW  = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE     = 2'd3;
   localparam logic [ACT_W-1:0]     ACT_UNUSED_LO = 3'd5;
   localparam logic [ACT_W-1:0]     ACT_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ADDR_W-1:0] address;
   } page_req_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [ADDR_W-1:0]             req_tdata = '0;  // phys_address
   logic [ACT_W-1:0]              req_tuser = '0;  // action
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // page_address [63:0], ref_value [79:64]
   logic [ADDR_W+OUT_REF_W-1:0]   rsp_tdata;
   logic [STAT_W-1:0]             rsp_tuser;       // status
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [PFN_W-1:0]              csr_wdata = '0;

   page_frame_allocator_refcount #(
      .NUM_FRAMES(NUM_FRAMES),
      .REF_WIDTH (REF_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Allocator shadow state.
   bit [FRAME_W-1:0]  link_mem   [NUM_FRAMES];
   bit [REF_BITS-1:0] frame_refs [NUM_FRAMES];
   bit [FRAME_W-1:0]  list_head;
   bit [CNT_W-1:0]    list_depth;
   bit [CNT_W-1:0]    fresh_next_frame;
   bit [CNT_W-1:0]    free_frames;
   bit [PFN_W-1:0]    cfg_base;
   bit [CNT_W-1:0]    cfg_frames;
   bit [CNT_W-1:0]    cfg_reserve = RESERVE_RESET;

   page_req_type pending_reqs  [$];
   rsp_type      expected_rsps [$];

   int send_idle_pct;
   int recv_idle_pct;
   int long_stall_reqs;
   int stall_served;
   int stall_left;
   int mismatches;
   int results_checked;
   int outcome_tally [8];
   int pool_settings;
   int cycle_count;

   function automatic bit [CNT_W-1:0] usable_frames();
      return (cfg_frames > NUM_FRAMES) ? CNT_W'(NUM_FRAMES) : cfg_frames;
   endfunction

   function automatic rsp_type serve_request(input logic [ACT_W-1:0] act,
                                             input logic [ADDR_W-1:0] addr);
      rsp_type           res;
      bit [CNT_W-1:0]    span;
      bit [PFN_W-1:0]    page_pfn;
      bit [PFN_W-1:0]    offset_frames;
      bit [FRAME_W-1:0]  f;
      logic [ADDR_W-1:0] pfn_total;
      span = usable_frames();
      res.page      = addr;
      res.ref_value = '0;
      res.status    = ST_OK;
      if (act == ACT_ALLOC) begin
         res.page = '0;
         if (free_frames < cfg_reserve || free_frames == 0 ||
             (list_depth == 0 && fresh_next_frame >= span)) begin
            res.status = ST_OOM;
         end else begin
            if (list_depth != 0) begin
               f = list_head;
               list_head = link_mem[f];
               list_depth--;
            end else begin
               f = fresh_next_frame[FRAME_W-1:0];
               fresh_next_frame++;
            end
            free_frames--;
            // Alloc saturates the count without flagging it.
            if (frame_refs[f] != REF_TOP)
               frame_refs[f]++;
            res.ref_value = OUT_REF_W'(frame_refs[f]);
            pfn_total = {{(ADDR_W-PFN_W){1'b0}}, cfg_base} + ADDR_W'(f);
            res.page = pfn_total << PAGE_SHIFT;
         end
      end else if (act <= ACT_QUERY) begin
         page_pfn      = addr[ADDR_W-1:PAGE_SHIFT];
         offset_frames = page_pfn - cfg_base;
         if (page_pfn < cfg_base || offset_frames >= PFN_W'(span)) begin
            res.status = ST_ADDR;
         end else begin
            f = offset_frames[FRAME_W-1:0];
            case (act)
               ACT_FREE: begin
                  if (list_depth != CNT_MAX) begin
                     link_mem[f] = list_head;
                     list_head = f;
                     list_depth++;
                     if (free_frames != CNT_MAX)
                        free_frames++;
                  end
               end
               ACT_INC: begin
                  if (frame_refs[f] == REF_TOP)
                     res.status = ST_OVERFLOW;
                  else
                     frame_refs[f]++;
               end
               ACT_DEC: begin
                  if (frame_refs[f] == 0)
                     res.status = ST_UNDERFLOW;
                  else
                     frame_refs[f]--;
               end
               default: ;
            endcase
            res.ref_value = OUT_REF_W'(frame_refs[f]);
         end
      end
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] frame_page(input int f);
      logic [ADDR_W-1:0] pfn_total;
      pfn_total = {{(ADDR_W-PFN_W){1'b0}}, cfg_base} + ADDR_W'(f);
      return (pfn_total << PAGE_SHIFT) | ADDR_W'($urandom_range(4095));
   endfunction

   function automatic logic [ADDR_W-1:0] any_address();
      return {$urandom, $urandom};
   endfunction

   task automatic add_req(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr);
      page_req_type item;
      item.action  = act;
      item.address = addr;
      pending_reqs.push_back(item);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PFN_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_POOL_BASE: cfg_base = value;
         CSR_POOL_FRAMES: begin
            // A new pool size restarts the free list; counts survive.
            cfg_frames       = value[CNT_W-1:0];
            free_frames      = usable_frames();
            fresh_next_frame = '0;
            list_depth       = '0;
            list_head        = '0;
         end
         CSR_RESERVE: cfg_reserve = value[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Mostly well-formed traffic on a few hot frames, with some noise mixed in.
   task automatic queue_traffic(input int count);
      int                span;
      int                hot;
      int                pick;
      logic [ACT_W-1:0]  act;
      span = int'(usable_frames());
      hot  = (span > HOT_WINDOW) ? HOT_WINDOW : span;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            add_req(ACT_ALLOC, any_address());
         end else if (pick < 88) begin
            if (pick < 50)
               act = ACT_FREE;
            else if (pick < 65)
               act = ACT_INC;
            else if (pick < 80)
               act = ACT_DEC;
            else
               act = ACT_QUERY;
            if (hot == 0)
               add_req(act, any_address());
            else
               add_req(act, frame_page($urandom_range(hot - 1)));
         end else begin
            case ($urandom_range(2))
               0: add_req(ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)),
                          any_address());
               1: add_req(ACT_W'($urandom_range(ACT_FREE, ACT_QUERY)), any_address());
               default: begin
                  act = ACT_W'($urandom_range(ACT_FREE, ACT_QUERY));
                  if ($urandom_range(1) == 0)
                     add_req(act, frame_page(-1));
                  else
                     add_req(act, frame_page(span));
               end
            endcase
         end
      end
   endtask

   task automatic traffic_phase(input logic [PFN_W-1:0] base, input logic [PFN_W-1:0] frames,
                                input logic [PFN_W-1:0] reserve, input int count,
                                input bit stall_midway);
      wait_idle();
      set_reg(CSR_POOL_BASE, base);
      set_reg(CSR_POOL_FRAMES, frames);
      set_reg(CSR_RESERVE, reserve);
      pool_settings++;
      @(negedge clock);
      queue_traffic(count / 2);
      if (stall_midway)
         long_stall_reqs++;
      // The sender stops here until every outstanding result is back.
      wait_idle();
      queue_traffic(count - count / 2);
   endtask

   always @(posedge clock) begin : drive_reqs
      page_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(serve_request(req_tuser, req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.action;
               req_tdata  <= nxt.address;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_served != long_stall_reqs) begin
         stall_served <= long_stall_reqs;
         stall_left   <= LONG_STALL;
         rsp_tready   <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_rsps
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         outcome_tally[rsp_tuser]++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected item page %h count %0d status %0d", $time,
                     rsp_tdata[ADDR_W-1:0], rsp_tdata[ADDR_W+OUT_REF_W-1:ADDR_W], rsp_tuser);
            mismatches++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tdata[ADDR_W-1:0] !== want.page) begin
               $display("%0t: page_address expected %h actual %h", $time, want.page,
                        rsp_tdata[ADDR_W-1:0]);
               mismatches++;
            end
            if (rsp_tdata[ADDR_W+OUT_REF_W-1:ADDR_W] !== want.ref_value) begin
               $display("%0t: ref_value expected %0d actual %0d", $time, want.ref_value,
                        rsp_tdata[ADDR_W+OUT_REF_W-1:ADDR_W]);
               mismatches++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time, expected_rsps.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin : main_seq
      logic [PFN_W-1:0] base;
      send_idle_pct = 35;
      recv_idle_pct = 55;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // The count store is cleared after reset; wait until requests are taken.
      while (req_tready !== 1'b1)
         @(negedge clock);

      // Empty pool at reset values: alloc is refused, query is outside, unused actions give OK.
      set_reg(CSR_SPARE, '1);
      @(negedge clock);
      add_req(ACT_ALLOC, '1);
      add_req(ACT_QUERY, '0);
      add_req(ACT_UNUSED_LO, '1);
      add_req(ACT_UNUSED_HI, '0);
      wait_idle();

      // Six-frame pool: list reuse, count underflow, pool edges and exhaustion.
      base = {1'b0, $urandom, 19'($urandom)};
      set_reg(CSR_POOL_BASE, base);
      set_reg(CSR_POOL_FRAMES, 52'd6);
      set_reg(CSR_RESERVE, 52'd0);
      pool_settings = 2;
      @(negedge clock);
      add_req(ACT_ALLOC, '0);
      add_req(ACT_ALLOC, '1);
      add_req(ACT_FREE, frame_page(0));
      add_req(ACT_ALLOC, '0);
      add_req(ACT_DEC, frame_page(1));
      add_req(ACT_DEC, frame_page(1));
      repeat (6) add_req(ACT_INC, frame_page(0));
      add_req(ACT_QUERY, frame_page(0));
      add_req(ACT_FREE, frame_page(0));
      add_req(ACT_ALLOC, '0);
      add_req(ACT_QUERY, frame_page(-1));
      add_req(ACT_QUERY, frame_page(6));
      add_req(ACT_INC, '1);
      repeat (5) add_req(ACT_ALLOC, '0);

      traffic_phase({1'b0, $urandom, 19'($urandom)}, 52'd16, 52'd2, 200, 1'b1);
      traffic_phase('1, 52'(CNT_MAX), 52'd65536, 80, 1'b0);
      wait_idle();
      send_idle_pct = 55;
      recv_idle_pct = 35;
      traffic_phase('0, 52'd65536, 52'd0, 250, 1'b1);
      traffic_phase({$urandom, 20'($urandom)}, 52'd1, 52'd1, 120, 1'b0);
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      traffic_phase({$urandom, 20'($urandom)}, 52'd40, 52'(CNT_MAX), 40, 1'b0);
      traffic_phase({$urandom, 20'($urandom)}, {$urandom, 3'($urandom), 17'd12}, 52'd3,
                    260, 1'b0);
      wait_idle();

      $display("Checked %0d results over %0d pool settings, with long output stalls.",
               results_checked, pool_settings);
      $display("Outcomes: ok %0d, no memory %0d, outside pool %0d, underflow %0d, overflow %0d",
               outcome_tally[ST_OK], outcome_tally[ST_OOM], outcome_tally[ST_ADDR],
               outcome_tally[ST_UNDERFLOW], outcome_tally[ST_OVERFLOW]);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
